// File: hdl/nais_pkg.sv
package nais_pkg;

  // Default table depth and the one-degree step in the angle format
  localparam int TABLE_DEPTH_DEF = 64;
  localparam logic [16:0] ONE_DEGREE = 17'd256;
  localparam logic [6:0] ENTRY_COUNT_RESET = 7'd52;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_PROBE,
    ST_CHK_MID,
    ST_CHK_LOWER,
    ST_CHK_UPPER,
    ST_DONE
  } state_t;

  // Table read address source
  typedef enum logic [2:0] {
    RA_FIRST,
    RA_LAST,
    RA_MID,
    RA_LOWER,
    RA_UPPER
  } rd_sel_t;

  // Result source
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_LAST,
    RES_MID,
    RES_PICK_LOWER,
    RES_PICK_UPPER
  } res_sel_t;

  typedef struct packed {
    logic     mem_wr;
    logic     capture;
    logic     start_probe;
    logic     save_v;
    logic     set_hi;
    logic     set_lo;
    logic     res_load;
    res_sel_t res_sel;
    rd_sel_t  rd_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic a_le;
    logic a_eq;
    logic a_lt;
    logic near_last;
    logic mid_gt0;
    logic upper_ok;
    logic range_open;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/nearest_angle_index_search.sv
// Nearest angle index search over a sorted table of angles (degrees x 256).
// Input words: tuser selects the kind (0 writes a table entry, 1 queries).
// A write word stores entry_value at entry_index and gives no
// output word. A query word returns the index of the nearest table entry
// on the output channel; ties between neighbors go to the upper entry.
// The cfg channel sets the number of valid entries (always ready); write it
// only while no query is in flight.
// A query holds the block until it ends: at the first-entry check when the
// angle is at or below the first entry, at the last-entry check when it
// reaches the last-entry threshold, else after a run of probes (address,
// registered table read, optional neighbor read) and a closing step when
// the probes run out without a hit. With 64 entries that is at most 7 probes.
// The single read port of the table memory sets these steps. One item at a time.
// A finished result sits in the output register; the block accepts the
// next word while it waits, and a following query stalls in its last state
// until the receiver takes the pending word.
// Reset clears the controller and the output valid and sets the entry
// count to 52; table contents are undefined until written.
module nearest_angle_index_search #(
  parameter int TABLE_DEPTH = nais_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // entry_index[5:0], entry_value[21:6], query_angle[37:22]
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // nearest_index[5:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // entry_count
);
  import nais_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  nais_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nais_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .wr_index    (in_tdata[5:0]),
    .wr_value    (in_tdata[21:6]),
    .query_angle (in_tdata[37:22]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// File: hdl/nais_dpath.sv
module nais_dpath #(
  parameter int TABLE_DEPTH = nais_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nais_pkg::cmd_t cmd,
  output nais_pkg::sts_t sts,
  input  logic [5:0]     wr_index,
  input  logic [15:0]    wr_value,
  input  logic [15:0]    query_angle,
  input  logic           cfg_valid,
  input  logic [6:0]     cfg_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata
);
  import nais_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [15:0]   mem [TABLE_DEPTH];
  logic [15:0]   rd_data_r;
  logic [AW-1:0] rd_addr;

  logic [6:0]    entry_count_r;
  logic [15:0]   angle_r;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [15:0]   v_r;
  logic [AW-1:0] res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_data_r;

  logic [CW-1:0] n_cnt;
  logic [CW-1:0] n_m1;
  logic [CW:0]   mid_sum;
  logic [CW:0]   mid_p1;
  logic [15:0]   below_lo, above_lo, below_up, above_up;

  // Clamp the entry count to 1..TABLE_DEPTH
  always_comb begin
    if (entry_count_r == 7'd0) begin
      n_cnt = CW'(1);
    end else if (32'(entry_count_r) > TABLE_DEPTH) begin
      n_cnt = CW'(TABLE_DEPTH);
    end else begin
      n_cnt = CW'(entry_count_r);
    end
  end

  assign n_m1    = n_cnt - CW'(1);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_p1  = {1'b0, mid_r} + (CW+1)'(1);

  // Select the table read address
  always_comb begin
    case (cmd.rd_sel)
      RA_FIRST: rd_addr = '0;
      RA_LAST:  rd_addr = n_m1[AW-1:0];
      RA_MID:   rd_addr = mid_sum[AW:1];
      RA_LOWER: rd_addr = AW'(mid_r - CW'(1));
      RA_UPPER: rd_addr = mid_p1[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (32'(wr_index) < TABLE_DEPTH)) begin
      mem[AW'(wr_index)] <= wr_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Distances for the two neighbor picks
  assign below_lo = angle_r - rd_data_r;
  assign above_lo = v_r - angle_r;
  assign below_up = angle_r - v_r;
  assign above_up = rd_data_r - angle_r;

  // Search bounds and probe point
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    mid_nxt = mid_r;
    if (cmd.capture) begin
      lo_nxt = '0;
      hi_nxt = n_cnt;
    end
    if (cmd.start_probe) begin
      mid_nxt = mid_sum[CW:1];
    end
    if (cmd.set_hi) begin
      hi_nxt = mid_r;
    end
    if (cmd.set_lo) begin
      lo_nxt = mid_p1[CW-1:0];
    end
  end

  // Result select
  always_comb begin
    res_nxt = res_r;
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ZERO:       res_nxt = '0;
        RES_LAST:       res_nxt = n_m1[AW-1:0];
        RES_MID:        res_nxt = mid_r[AW-1:0];
        RES_PICK_LOWER: res_nxt = (below_lo >= above_lo) ? mid_r[AW-1:0]
                                                         : AW'(mid_r - CW'(1));
        RES_PICK_UPPER: res_nxt = (below_up >= above_up) ? mid_p1[AW-1:0]
                                                         : mid_r[AW-1:0];
        default:        res_nxt = '0;
      endcase
    end
  end

  // Output register: hold the word until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        entry_count_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      angle_r <= query_angle;
    end
    if (cmd.save_v) begin
      v_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_data_r <= 6'(res_r);
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    res_r <= res_nxt;
  end

  // Status to the controller
  assign sts.a_le       = angle_r <= rd_data_r;
  assign sts.a_eq       = angle_r == rd_data_r;
  assign sts.a_lt       = angle_r < rd_data_r;
  assign sts.near_last  = ({1'b0, angle_r} + ONE_DEGREE) >= {1'b0, rd_data_r};
  assign sts.mid_gt0    = mid_r != '0;
  assign sts.upper_ok   = mid_p1 < {1'b0, n_cnt};
  assign sts.range_open = lo_r < hi_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

// File: hdl/nais_ctrl.sv
module nais_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_req,
  output logic           in_tready,
  input  nais_pkg::sts_t sts,
  output nais_pkg::cmd_t cmd
);
  import nais_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence the end checks and the probes of the search
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.rd_sel      = RA_FIRST;
    cmd.res_sel     = RES_ZERO;
    in_tready       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_req == REQ_QUERY) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_CHK_FIRST;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      ST_CHK_FIRST: begin
        cmd.rd_sel = RA_LAST;
        if (sts.a_le) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_nxt    = ST_DONE;
        end else begin
          state_nxt = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (sts.near_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_LAST;
          state_nxt    = ST_DONE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts.range_open) begin
          cmd.rd_sel      = RA_MID;
          cmd.start_probe = 1'b1;
          state_nxt       = ST_CHK_MID;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MID;
          state_nxt    = ST_DONE;
        end
      end
      ST_CHK_MID: begin
        cmd.save_v = 1'b1;
        if (sts.a_eq) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MID;
          state_nxt    = ST_DONE;
        end else if (sts.a_lt) begin
          if (sts.mid_gt0) begin
            cmd.rd_sel = RA_LOWER;
            state_nxt  = ST_CHK_LOWER;
          end else begin
            cmd.set_hi = 1'b1;
            state_nxt  = ST_PROBE;
          end
        end else begin
          if (sts.upper_ok) begin
            cmd.rd_sel = RA_UPPER;
            state_nxt  = ST_CHK_UPPER;
          end else begin
            cmd.set_lo = 1'b1;
            state_nxt  = ST_PROBE;
          end
        end
      end
      ST_CHK_LOWER: begin
        // Angle above the lower neighbor: the pair encloses it
        if (!sts.a_le) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PICK_LOWER;
          state_nxt    = ST_DONE;
        end else begin
          cmd.set_hi = 1'b1;
          state_nxt  = ST_PROBE;
        end
      end
      ST_CHK_UPPER: begin
        if (sts.a_lt) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PICK_UPPER;
          state_nxt    = ST_DONE;
        end else begin
          cmd.set_lo = 1'b1;
          state_nxt  = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
